@@ hw/rtl/dzrp_pkg.sv @@
// Package: shared types and constants for the digital zoom ROI planner.
`default_nettype none
package dzrp_pkg;
  localparam int unsigned FullK = 1000;
  localparam int unsigned HalfK = 500;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RATIO = 2'd1,
    ST_PAN   = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_ZOOM_MIN = 1'b0,
    REG_ZOOM_MAX = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_PREP, S_DIV_PS, S_PREV, S_DIV_S, S_MUL, S_DIVF, S_PLACE,
    S_WRITE, S_OUT
  } fsm_e;

  // stored per channel state
  typedef struct packed {
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [11:0] ratio;
    logic        en;
  } chan_t;

  typedef struct packed {
    logic [4:0]        channel;
    logic              enable;
    logic signed [11:0] center_x;
    logic signed [11:0] center_y;
    logic signed [11:0] focus_x;
    logic signed [11:0] focus_y;
    logic [11:0]       zoom_ratio;
  } req_t;

  typedef struct packed {
    logic [9:0]  crop_x;
    logic [9:0]  crop_y;
    logic [9:0]  crop_side;
    logic [9:0]  new_center_x;
    logic [9:0]  new_center_y;
    logic [11:0] new_ratio;
    logic [1:0]  status;
  } res_t;

  // clamp signed thousandths to 0..1000
  function automatic logic [9:0] clamp_k(input logic signed [11:0] v);
    logic [9:0] r;
    if (v < 0) r = '0;
    else if (v > 12'sd1000) r = 10'd1000;
    else r = v[9:0];
    return r;
  endfunction
endpackage
`default_nettype wire

@@ hw/rtl/dzrp_if.sv @@
// Interfaces: valid/ready item channels and the register write channel.
`default_nettype none
interface dzrp_req_if;
  logic              valid;
  logic              ready;
  dzrp_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dzrp_res_if;
  logic              valid;
  logic              ready;
  dzrp_pkg::res_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dzrp_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [11:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dzrp_div.sv @@
// Module: restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module dzrp_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [19:0] num_i,
  input  wire logic [11:0] den_i,
  output logic             done_o,
  output logic [19:0]      quo_o
);
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [19:0] quo_q, quo_d;
  logic [12:0] rem_q, rem_d;
  logic [11:0] den_q, den_d;
  logic [12:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_o = 1'b0;
    trial  = {rem_q[11:0], quo_q[19]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[18:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd19) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  assign quo_o = quo_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end
endmodule
`default_nettype wire

@@ hw/rtl/digital_zoom_roi_planner.sv @@
// Top level: per-channel digital zoom and pan planner.
// One request at a time. The channel's stored center and ratio come from the
// per-channel memory, read through a register. The crop side needs a division
// by the ratio, done on a bit-serial divider. A request with a focus point
// needs a second one for the previous crop side, and four products divided
// by 1000 through a reciprocal multiply, one per cycle. Then come placement,
// the write back and the result register. The two ratio divisions dominate
// the time to a result. The next item is taken the cycle after the result
// leaves, so receiver stalls add directly.
// The memory has no clear pass: one valid bit per channel, cleared at reset,
// makes an unwritten channel read as 500,500, ratio 100.
// Requests for channels at or above CHANNELS are consumed with no result.
`default_nettype none
module digital_zoom_roi_planner #(
  parameter int unsigned CHANNELS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dzrp_req_if.sink   req,
  dzrp_res_if.source res,
  dzrp_cfg_if.sink   cfg
);
  // the channel field is 5 bits wide, so never index with more
  localparam int unsigned AW = (CHANNELS > 32) ? 5 :
                               ((CHANNELS > 1) ? $clog2(CHANNELS) : 1);
  // ceil(2^29 / 1000); exact floor(n / 1000) for any n below 2^20
  localparam logic [19:0] RecipK = 20'd536871;

  dzrp_pkg::fsm_e state_q, state_d;
  dzrp_pkg::req_t req_q;
  dzrp_pkg::chan_t mem_rd_q, prev;
  dzrp_pkg::res_t  res_q;
  logic        res_valid_q;
  logic [9:0]  zmin_q;
  logic [11:0] zmax_q;
  logic [CHANNELS-1:0] vld_q;
  logic        vld_rd_q;
  dzrp_pkg::chan_t mem [CHANNELS];

  // working registers
  logic [9:0]  side_q, ps_q, px_q, py_q;
  logic [11:0] ratio_q;
  logic [1:0]  status_q;
  logic [9:0]  fx_q, fy_q;
  logic [19:0] m0_q, m1_q, m2_q, m3_q;
  logic [9:0]  q_q [4];
  logic [1:0]  dsel_q;
  logic        focus_q;

  logic [9:0]  emin;
  logic [11:0] emax;
  assign emin = (zmin_q == '0) ? 10'd1 : zmin_q;
  assign emax = (zmax_q == '0) ? 12'd1 : zmax_q;

  // divider
  logic        div_start;
  logic [19:0] div_num;
  logic [11:0] div_den;
  logic        div_done;
  logic [19:0] div_quo;

  dzrp_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic in_range;
  assign in_range = (32'(req.data.channel) < CHANNELS);
  assign req.ready = (state_q == dzrp_pkg::S_IDLE) && !res_valid_q;
  assign cfg.ready = 1'b1;
  assign res.valid = res_valid_q;
  assign res.data  = res_q;

  assign prev = vld_rd_q ? mem_rd_q :
                dzrp_pkg::chan_t'{cx: 10'(dzrp_pkg::HalfK), cy: 10'(dzrp_pkg::HalfK),
                                  ratio: 12'd100, en: 1'b1};

  // side helpers
  function automatic logic [11:0] raise(input logic [11:0] r, input logic [9:0] m);
    return (r < {2'b0, m}) ? {2'b0, m} : r;
  endfunction
  function automatic logic [9:0] sat_side(input logic [19:0] s);
    logic [9:0] r;
    if (s == '0) r = 10'd1;
    else if (s > 20'd1000) r = 10'd1000;
    else r = s[9:0];
    return r;
  endfunction
  function automatic logic [9:0] corner(input logic [9:0] c, input logic [9:0] s);
    logic signed [11:0] v;
    logic signed [11:0] hi;
    logic [9:0] r;
    v  = $signed({2'b0, c}) - $signed({3'b0, s[9:1]});
    hi = 12'sd1000 - $signed({2'b0, s});
    if (v < 0) r = '0;
    else if (v > hi) r = hi[9:0];
    else r = v[9:0];
    return r;
  endfunction

  logic [11:0] r_prev, r_new;
  assign r_prev = raise(prev.ratio, emin);
  assign r_new  = raise(ratio_q, emin);

  // focus products divided by 1000, one per cycle
  logic [19:0] fdiv_num;
  logic [39:0] fdiv_prod;
  logic [9:0]  fdiv_quo;
  always_comb begin
    case (dsel_q)
      2'd0:    fdiv_num = m0_q;
      2'd1:    fdiv_num = m1_q;
      2'd2:    fdiv_num = m2_q;
      default: fdiv_num = m3_q;
    endcase
    fdiv_prod = fdiv_num * RecipK;
    fdiv_quo  = fdiv_prod[38:29];
  end

  // placement
  logic signed [12:0] xs, ys, hi13;
  logic [9:0]  xf, yf;
  logic        clx, cly;
  always_comb begin
    if (focus_q) begin
      xs = $signed({3'b0, px_q}) + $signed({3'b0, q_q[0]}) - $signed({3'b0, q_q[1]});
      ys = $signed({3'b0, py_q}) + $signed({3'b0, q_q[2]}) - $signed({3'b0, q_q[3]});
    end else begin
      xs = $signed({3'b0, dzrp_pkg::clamp_k(req_q.center_x)}) - $signed({4'b0, side_q[9:1]});
      ys = $signed({3'b0, dzrp_pkg::clamp_k(req_q.center_y)}) - $signed({4'b0, side_q[9:1]});
    end
    hi13 = 13'sd1000 - $signed({3'b0, side_q});
    clx = 1'b0; cly = 1'b0;
    if (xs < 0) begin xf = '0; clx = 1'b1; end
    else if (xs > hi13) begin xf = hi13[9:0]; clx = 1'b1; end
    else xf = xs[9:0];
    if (ys < 0) begin yf = '0; cly = 1'b1; end
    else if (ys > hi13) begin yf = hi13[9:0]; cly = 1'b1; end
    else yf = ys[9:0];
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = 12'd1;
    case (state_q)
      dzrp_pkg::S_IDLE: if (req.valid && req.ready && in_range) state_d = dzrp_pkg::S_READ;
      dzrp_pkg::S_READ: state_d = dzrp_pkg::S_PREP;
      dzrp_pkg::S_PREP: begin
        if (!req_q.enable) state_d = dzrp_pkg::S_WRITE;
        else if (focus_q) begin
          div_start = 1'b1;
          div_num   = 20'(emin) * 20'(dzrp_pkg::FullK) + 20'(r_prev[11:1]);
          div_den   = r_prev;
          state_d   = dzrp_pkg::S_DIV_PS;
        end else state_d = dzrp_pkg::S_PREV;
      end
      dzrp_pkg::S_DIV_PS: if (div_done) state_d = dzrp_pkg::S_PREV;
      dzrp_pkg::S_PREV: begin
        div_start = 1'b1;
        div_num   = 20'(emin) * 20'(dzrp_pkg::FullK) + 20'(r_new[11:1]);
        div_den   = r_new;
        state_d   = dzrp_pkg::S_DIV_S;
      end
      dzrp_pkg::S_DIV_S: if (div_done) state_d = focus_q ? dzrp_pkg::S_MUL : dzrp_pkg::S_PLACE;
      dzrp_pkg::S_MUL:   state_d = dzrp_pkg::S_DIVF;
      dzrp_pkg::S_DIVF:  if (dsel_q == 2'd3) state_d = dzrp_pkg::S_PLACE;
      dzrp_pkg::S_PLACE: state_d = dzrp_pkg::S_WRITE;
      dzrp_pkg::S_WRITE: state_d = dzrp_pkg::S_OUT;
      dzrp_pkg::S_OUT:   state_d = dzrp_pkg::S_IDLE;
      default:           state_d = dzrp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dzrp_pkg::S_IDLE;
      res_valid_q <= 1'b0;
      zmin_q      <= 10'd100;
      zmax_q      <= 12'd1000;
      vld_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg.valid) begin
        case (cfg.index)
          dzrp_pkg::REG_ZOOM_MIN: zmin_q <= cfg.wdata[9:0];
          dzrp_pkg::REG_ZOOM_MAX: zmax_q <= cfg.wdata;
          default: ;
        endcase
      end
      if (state_q == dzrp_pkg::S_WRITE) vld_q[req_q.channel[AW-1:0]] <= 1'b1;
      if (state_q == dzrp_pkg::S_OUT) res_valid_q <= 1'b1;
      else if (res.ready) res_valid_q <= 1'b0;
    end
  end

  // channel memory, read every cycle, written back in S_WRITE
  always_ff @(posedge clk_i) begin
    if (state_q == dzrp_pkg::S_WRITE)
      mem[req_q.channel[AW-1:0]] <= '{cx: res_q.new_center_x, cy: res_q.new_center_y,
                                      ratio: res_q.new_ratio, en: req_q.enable};
    mem_rd_q <= mem[req_q.channel[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      req_q   <= req.data;
      focus_q <= (dzrp_pkg::clamp_k(req.data.focus_x) != 10'(dzrp_pkg::HalfK)) ||
                 (dzrp_pkg::clamp_k(req.data.focus_y) != 10'(dzrp_pkg::HalfK));
      fx_q    <= dzrp_pkg::clamp_k(req.data.focus_x);
      fy_q    <= dzrp_pkg::clamp_k(req.data.focus_y);
    end
    if (state_q == dzrp_pkg::S_READ) vld_rd_q <= vld_q[req_q.channel[AW-1:0]];
    if (state_q == dzrp_pkg::S_PREP) begin
      if (req_q.zoom_ratio > emax) begin
        ratio_q  <= emax;
        status_q <= dzrp_pkg::ST_RATIO;
      end else begin
        status_q <= dzrp_pkg::ST_OK;
        if (req_q.zoom_ratio < {2'b0, emin}) ratio_q <= {2'b0, emin};
        else ratio_q <= req_q.zoom_ratio;
      end
    end
    if (state_q == dzrp_pkg::S_DIV_PS && div_done) begin
      ps_q <= sat_side(div_quo);
      px_q <= corner(prev.cx, sat_side(div_quo));
      py_q <= corner(prev.cy, sat_side(div_quo));
    end
    if (state_q == dzrp_pkg::S_DIV_S && div_done) side_q <= sat_side(div_quo);
    if (state_q == dzrp_pkg::S_MUL) begin
      m0_q <= 20'(ps_q) * 20'(fx_q);
      m1_q <= 20'(side_q) * 20'(fx_q);
      m2_q <= 20'(ps_q) * 20'(fy_q);
      m3_q <= 20'(side_q) * 20'(fy_q);
      dsel_q <= 2'd0;
    end
    if (state_q == dzrp_pkg::S_DIVF) begin
      q_q[dsel_q] <= fdiv_quo;
      dsel_q <= dsel_q + 2'd1;
    end
    if (state_q == dzrp_pkg::S_PREP && !req_q.enable) begin
      res_q <= '{crop_x: '0, crop_y: '0, crop_side: 10'd1000, new_center_x: 10'd500,
                 new_center_y: 10'd500, new_ratio: {2'b0, emin}, status: dzrp_pkg::ST_OK};
    end
    if (state_q == dzrp_pkg::S_PLACE) begin
      res_q.crop_x       <= xf;
      res_q.crop_y       <= yf;
      res_q.crop_side    <= side_q;
      res_q.new_center_x <= xf + {1'b0, side_q[9:1]};
      res_q.new_center_y <= yf + {1'b0, side_q[9:1]};
      res_q.new_ratio    <= ratio_q;
      res_q.status       <= ((clx || cly) && status_q == dzrp_pkg::ST_OK) ?
                            dzrp_pkg::ST_PAN : status_q;
    end
  end

  ap_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dzrp_pkg::S_IDLE) |-> !req.ready) else $error("ready while busy");
  ap_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dzrp_pkg::S_OUT) |=> res_valid_q) else $error("result lost");
  ap_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.status != 2'd3)) else $error("bad status");
endmodule
`default_nettype wire
